// ===== rtl/psag_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psag_pkg
// Shared types and constants for the parabolic sine approximation generator.
// ----------------------------------------------------------------------------
package psag_pkg;

  // Field and register widths.
  localparam int CountW = 7;
  localparam int PeriodW = 16;
  localparam int AmpW = 15;
  localparam int SampleW = 16;
  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 16;

  // Longest run of samples that one request may ask for.
  localparam logic [CountW-1:0] MAX_RUN = 7'd64;

  // The quotient is never larger than the amplitude, so one bit per step over
  // the amplitude width covers it.
  localparam int DivSteps = AmpW;
  localparam logic [3:0] DIV_LAST = 4'(DivSteps - 1);

  // Configuration register indexes.
  localparam logic [CfgAddrW-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_AMPLITUDE = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_START_OFFSET = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mul1;
    logic mul2;
    logic div_step;
    logic out_load;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_load;
  } sts_t;

endpackage

// ===== rtl/parabolic_sine_approx_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parabolic_sine_approx_generator
// Emits a sine-like wave built from alternating parabolic arches, one run of
// samples per request, with a write port for period, amplitude and offset.
//
//   Channel | Direction | Transaction
//   in_     | slave     | one run request (sample count)
//   out_    | master    | one wave sample, tlast on the final sample of a run
//   cfg_    | write     | one register write, a known register reloads the wave position
//
// A request is taken while the controller is idle; each sample then passes
// through two multiply steps, the restoring divider (one step per quotient
// bit) and an emit step. The output register lets the next sample be
// computed while one waits; a stalled output holds the emit step. Reset
// clears the control state.
// ----------------------------------------------------------------------------
module parabolic_sine_approx_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] sample_count, [7] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample_value
  output logic        out_tlast,  // last_sample
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_data
);
  import psag_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing.
  psag_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_count (in_tdata[CountW-1:0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and output.
  psag_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // A non-empty request makes the block busy in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[6:0] != 7'd0) |=> !in_tready)
    else $error("block not busy after accepting a run");

  // Loading the final sample of a run returns the controller to idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.last) |=> in_tready)
    else $error("controller not idle after the final sample");

  // A new sample never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !cmd.out_load)
    else $error("output register overwritten while stalled");

  // Every loaded sample appears on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_tvalid)
    else $error("loaded sample not presented");

endmodule

// ===== rtl/psag_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psag_ctrl
// Controller: accepts run requests, counts samples and divider steps, and
// sequences the datapath through multiply, divide and emit for each sample.
// ----------------------------------------------------------------------------
module psag_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [psag_pkg::CountW-1:0] in_count,
  input  psag_pkg::sts_t              sts,
  output psag_pkg::cmd_t              cmd
);
  import psag_pkg::*;

  state_t            state_r, state_nxt;
  logic [CountW-1:0] left_r, left_nxt;
  logic [3:0]        div_cnt_r, div_cnt_nxt;
  logic [CountW-1:0] count_sat;
  logic              start;

  // Requests above the maximum run length are clipped to it.
  assign count_sat = (in_count > MAX_RUN) ? MAX_RUN : in_count;
  assign start = (state_r == ST_IDLE) && in_tvalid && (in_count != '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_DIV;
      ST_DIV:  if (div_cnt_r == DIV_LAST) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.can_load) begin
          state_nxt = (left_r == 7'd1) ? ST_IDLE : ST_MUL1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sample and divider step counters.
  always_comb begin
    left_nxt = left_r;
    div_cnt_nxt = div_cnt_r;
    if (start) begin
      left_nxt = count_sat;
    end else if (state_r == ST_EMIT && sts.can_load) begin
      left_nxt = left_r - 7'd1;
    end
    if (state_r == ST_MUL2) begin
      div_cnt_nxt = '0;
    end else if (state_r == ST_DIV) begin
      div_cnt_nxt = div_cnt_r + 4'd1;
    end
  end

  // Commands to the datapath.
  always_comb begin
    in_tready = (state_r == ST_IDLE);
    cmd.mul1 = (state_r == ST_MUL1);
    cmd.mul2 = (state_r == ST_MUL2);
    cmd.div_step = (state_r == ST_DIV);
    cmd.out_load = (state_r == ST_EMIT) && sts.can_load;
    cmd.last = (left_r == 7'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      left_r <= '0;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      left_r <= left_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

endmodule

// ===== rtl/psag_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psag_dp
// Datapath: configuration registers, wave position, arch multipliers, a
// restoring divider by the squared half period, and the output register.
// ----------------------------------------------------------------------------
module psag_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [psag_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [psag_pkg::CfgDataW-1:0] cfg_data,
  input  psag_pkg::cmd_t                cmd,
  output psag_pkg::sts_t                sts,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [psag_pkg::SampleW-1:0]  out_tdata,
  output logic                          out_tlast
);
  import psag_pkg::*;

  // Configuration and position state.
  logic [PeriodW-1:0] half_r, half_nxt;
  logic [AmpW-1:0]    amp_r, amp_nxt;
  logic [PeriodW-1:0] offs_r, offs_nxt;
  logic [PeriodW-1:0] pos_r, pos_nxt;
  logic               neg_r, neg_nxt;
  logic               reload;
  logic [PeriodW-1:0] m_eff, m_eff_nxt;

  // Arithmetic pipeline.
  logic [31:0]        arch_r;
  logic [31:0]        msq_r;
  logic [46:0]        num;
  logic [31:0]        rem_r, rem_nxt;
  logic [AmpW-1:0]    quo_r, quo_nxt;
  logic [32:0]        trial;
  logic               ge;

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  logic [SampleW-1:0] out_data_r;
  logic               out_last_r;
  logic [SampleW-1:0] signed_val;

  // A zero half period behaves as one.
  assign m_eff = (half_r == '0) ? 16'd1 : half_r;

  // Register writes; any write to a known register reloads the position.
  always_comb begin
    half_nxt = half_r;
    amp_nxt = amp_r;
    offs_nxt = offs_r;
    reload = 1'b0;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_HALF_PERIOD: begin
          half_nxt = cfg_data;
          reload = 1'b1;
        end
        REG_AMPLITUDE: begin
          amp_nxt = cfg_data[AmpW-1:0];
          reload = 1'b1;
        end
        REG_START_OFFSET: begin
          offs_nxt = cfg_data;
          reload = 1'b1;
        end
        default: reload = 1'b0;
      endcase
    end
  end

  assign m_eff_nxt = (half_nxt == '0) ? 16'd1 : half_nxt;

  // Position update: reload on a write, advance after each emitted sample.
  always_comb begin
    pos_nxt = pos_r;
    neg_nxt = neg_r;
    if (reload) begin
      if (offs_nxt >= m_eff_nxt) begin
        pos_nxt = '0;
        neg_nxt = 1'b1;
      end else begin
        pos_nxt = offs_nxt;
        neg_nxt = 1'b0;
      end
    end else if (cmd.out_load) begin
      if (pos_r == m_eff - 16'd1) begin
        pos_nxt = '0;
        neg_nxt = ~neg_r;
      end else begin
        pos_nxt = pos_r + 16'd1;
      end
    end
  end

  // Second multiply: amplitude times 4*k*(m-k), which never exceeds m*m.
  assign num = {32'd0, amp_r} * {13'd0, arch_r, 2'b00};

  // One restoring division step per cycle; quotient bits shift in at the bottom.
  assign trial = {rem_r, quo_r[AmpW-1]};
  assign ge = (trial >= {1'b0, msq_r});

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (cmd.mul2) begin
      rem_nxt = num[46:15];
      quo_nxt = num[14:0];
    end else if (cmd.div_step) begin
      rem_nxt = ge ? 32'(trial - {1'b0, msq_r}) : trial[31:0];
      quo_nxt = {quo_r[AmpW-2:0], ge};
    end
  end

  // Sign from the half flag; the output register may load while being taken.
  assign signed_val = neg_r ? 16'(-{1'b0, quo_r}) : {1'b0, quo_r};
  assign sts.can_load = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 16'd1;
      amp_r <= '0;
      offs_r <= '0;
      pos_r <= '0;
      neg_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      half_r <= half_nxt;
      amp_r <= amp_nxt;
      offs_r <= offs_nxt;
      pos_r <= pos_nxt;
      neg_r <= neg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      arch_r <= {16'd0, pos_r} * {16'd0, m_eff - pos_r};
      msq_r <= {16'd0, m_eff} * {16'd0, m_eff};
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (cmd.out_load) begin
      out_data_r <= signed_val;
      out_last_r <= cmd.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;

endmodule

// ===== tb/parabolic_sine_approx_generator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parabolic_sine_approx_generator_test
// Self-checking bench for the parabolic wave generator. A table of directed
// requests and register writes covers the corner cases, then phases of random
// settings and random runs follow. Every sample is checked against a local
// model of the arch arithmetic, with random stalls on both streams.
// ----------------------------------------------------------------------------
module parabolic_sine_approx_generator_test;
  import psag_pkg::*;

  // Register index that lies beyond the register list.
  localparam logic [CfgAddrW-1:0] REG_UNUSED = 2'd3;

  localparam int RandomRequests = 330;
  localparam int SettleCycles = 60;
  localparam int DrainLimit = 200000;
  localparam int LongHoldCycles = 400;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] data;
    logic [CountW-1:0] count;
    logic typed;
    logic [SampleW-1:0] typed_value;
  } stim_row_t;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic last;
  } sample_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [7:0] in_tdata;    // [6:0] sample_count, [7] zero
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;  // [15:0] sample_value
  logic out_tlast;         // last_sample
  logic cfg_we;
  logic [1:0] cfg_addr;
  logic [15:0] cfg_data;

  // Local copy of the wave settings and position.
  logic [PeriodW-1:0] wave_period;
  logic [AmpW-1:0] wave_amplitude;
  logic [PeriodW-1:0] wave_offset;
  logic [PeriodW-1:0] wave_pos;
  logic wave_negative;

  sample_t pending_samples[$];
  stim_row_t stim_table[$];
  int unsigned mismatch_count;
  bit long_hold_pending;
  sample_t oldest;

  parabolic_sine_approx_generator dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    #100_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Idle length for either stream: mostly none or short, now and then long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A register write updates the settings and reloads the position.
  task automatic apply_register_write(input logic [CfgAddrW-1:0] addr,
                                      input logic [CfgDataW-1:0] data);
    logic [PeriodW:0] eff;
    case (addr)
      REG_HALF_PERIOD: wave_period = data;
      REG_AMPLITUDE: wave_amplitude = data[AmpW-1:0];
      REG_START_OFFSET: wave_offset = data;
      default: return;
    endcase
    eff = (wave_period == '0) ? 17'd1 : {1'b0, wave_period};
    if (wave_offset >= eff) begin
      wave_pos = '0;
      wave_negative = 1'b1;
    end else begin
      wave_pos = wave_offset;
      wave_negative = 1'b0;
    end
  endtask

  // Work out the samples of one run and queue them in order.
  task automatic predict_run(input logic [CountW-1:0] count);
    longint unsigned m;
    longint unsigned k;
    longint unsigned arch;
    longint unsigned mag;
    int unsigned n;
    sample_t s;
    m = (wave_period == '0) ? 64'd1 : 64'(wave_period);
    n = (count > MAX_RUN) ? 32'(MAX_RUN) : 32'(count);
    for (int i = n; i > 0; i--) begin
      k = wave_pos;
      arch = 4 * k * (m - k);
      mag = (wave_amplitude * arch) / (m * m);
      s.value = SampleW'(wave_negative ? (64'd0 - mag) : mag);
      s.last = (i == 1);
      pending_samples.push_back(s);
      if (longint'(wave_pos) + 1 >= m) begin
        wave_pos = '0;
        wave_negative = ~wave_negative;
      end else begin
        wave_pos = wave_pos + 1'b1;
      end
    end
  endtask

  function automatic void push_stim(input row_kind_t kind, input logic [CfgAddrW-1:0] addr,
                                    input logic [CfgDataW-1:0] data,
                                    input logic [CountW-1:0] count, input logic typed,
                                    input logic [SampleW-1:0] typed_value);
    stim_row_t row;
    row.kind = kind;
    row.addr = addr;
    row.data = data;
    row.count = count;
    row.typed = typed;
    row.typed_value = typed_value;
    stim_table.push_back(row);
  endfunction

  // Offer one run request after a gap; returns in the step it is accepted.
  task automatic send_request(input logic [CountW-1:0] count, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, count};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_run(count);
  endtask

  // Stop offering and wait until every queued sample has come out.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    if (pending_samples.size() != 0) begin
      $error("sample_value: %0d expected samples never arrived", pending_samples.size());
      mismatch_count++;
      pending_samples.delete();
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgAddrW-1:0] addr,
                                input logic [CfgDataW-1:0] data, input bit more);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    @(posedge clk);
    apply_register_write(addr, data);
    if (!more) cfg_we <= 1'b0;
  endtask

  function automatic logic [CountW-1:0] pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return CountW'($urandom_range(65, 127));
    if (r < 18) return MAX_RUN;
    if (r < 25) return CountW'($urandom_range(0, 127));
    return CountW'($urandom_range(1, 16));
  endfunction

  function automatic logic [CfgDataW-1:0] pick_reg_value(input logic [CfgAddrW-1:0] addr);
    int r;
    r = $urandom_range(0, 99);
    case (addr)
      REG_HALF_PERIOD: begin
        if (r < 10) return '0;
        if (r < 20) return 16'd1;
        if (r < 25) return 16'hFFFF;
        if (r < 40) return CfgDataW'($urandom_range(0, 65535));
        return CfgDataW'($urandom_range(1, 24));
      end
      REG_AMPLITUDE: begin
        if (r < 15) return 16'h7FFF;
        if (r < 25) return '0;
        if (r < 35) return 16'hFFFF;
        return CfgDataW'($urandom_range(0, 65535));
      end
      REG_START_OFFSET: begin
        if (r < 15) return '0;
        if (r < 25) return 16'hFFFF;
        if (r < 40) return CfgDataW'($urandom_range(0, 65535));
        return CfgDataW'($urandom_range(0, 30));
      end
      default: return CfgDataW'($urandom_range(0, 65535));
    endcase
  endfunction

  // Result checker: each sample transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        $error("sample_value: no sample expected, got %0d", $signed(out_tdata));
        mismatch_count++;
      end else begin
        oldest = pending_samples.pop_front();
        if (out_tdata !== oldest.value) begin
          $error("sample_value: expected %0d, got %0d", $signed(oldest.value),
                 $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tlast !== oldest.last) begin
          $error("last_sample: expected %0b, got %0b", oldest.last, out_tlast);
          mismatch_count++;
        end
      end
    end
  end

  // Sample receiver: random stalls, free-running stretches and one long hold.
  initial begin : output_receiver
    int stall_left;
    int free_left;
    int r;
    stall_left = 0;
    free_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        stall_left = LongHoldCycles;
        free_left = 0;
      end else if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) free_left = $urandom_range(20, 120);
        else if (r < 40) stall_left = pick_idle_len();
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (free_left > 0) free_left--;
      end
    end
  end

  // Stimulus: directed table, then random phases.
  initial begin : stimulus
    stim_row_t row;
    sample_t s;
    reg_write_t writes[$];
    reg_write_t w;
    int requests_sent;
    int phase;
    int batch_len;
    bit hold_phase;

    mismatch_count = 0;
    long_hold_pending = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    wave_period = 16'd1;
    wave_amplitude = '0;
    wave_offset = '0;
    wave_pos = '0;
    wave_negative = 1'b0;

    // Directed rows: reset values, amplitude mask, both arch peaks, offset
    // saturation, unused index, zero period, overlong and empty runs.
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h0000);
    push_stim(ROW_REQ, '0, '0, 7'd0, 1'b0, '0);
    push_stim(ROW_CFG, REG_AMPLITUDE, 16'hFFFF, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h0000);
    push_stim(ROW_CFG, REG_HALF_PERIOD, 16'd2, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h0000);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h7FFF);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h0000);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h8001);
    push_stim(ROW_CFG, REG_START_OFFSET, 16'hFFFF, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd3, 1'b0, '0);
    push_stim(ROW_CFG, REG_UNUSED, 16'hFFFF, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd2, 1'b0, '0);
    push_stim(ROW_CFG, REG_HALF_PERIOD, 16'd0, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd5, 1'b0, '0);
    push_stim(ROW_CFG, REG_HALF_PERIOD, 16'hFFFF, '0, 1'b0, '0);
    push_stim(ROW_CFG, REG_START_OFFSET, 16'd32767, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd127, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd64, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd65, 1'b0, '0);
    push_stim(ROW_CFG, REG_AMPLITUDE, 16'd0, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd1, 1'b1, 16'h0000);
    push_stim(ROW_CFG, REG_HALF_PERIOD, 16'd7, '0, 1'b0, '0);
    push_stim(ROW_CFG, REG_AMPLITUDE, 16'd1000, '0, 1'b0, '0);
    push_stim(ROW_CFG, REG_START_OFFSET, 16'd0, '0, 1'b0, '0);
    push_stim(ROW_REQ, '0, '0, 7'd33, 1'b0, '0);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the table; writes only once the block has drained.
    for (int i = 0; i < stim_table.size(); i++) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG) begin
        if (i == 0 || stim_table[i-1].kind != ROW_CFG) wait_idle();
        write_register(row.addr, row.data,
                       (i + 1 < stim_table.size()) && stim_table[i+1].kind == ROW_CFG);
      end else begin
        send_request(row.count, pick_idle_len());
        if (row.typed) begin
          s = pending_samples.pop_back();
          s.value = row.typed_value;
          pending_samples.push_back(s);
        end
      end
    end

    // Random phases: new settings, then a batch of requests.
    requests_sent = 0;
    phase = 0;
    while (requests_sent < RandomRequests) begin
      wait_idle();
      writes.delete();
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 99) < 60) begin
          w.addr = CfgAddrW'(a);
          w.data = pick_reg_value(w.addr);
          writes.push_back(w);
        end
      end
      if (writes.size() == 0 || $urandom_range(0, 9) == 0) begin
        w.addr = ($urandom_range(0, 3) == 0) ? REG_UNUSED : CfgAddrW'($urandom_range(0, 2));
        w.data = pick_reg_value(w.addr);
        writes.push_back(w);
      end
      for (int j = 0; j < writes.size(); j++)
        write_register(writes[j].addr, writes[j].data, j + 1 < writes.size());

      // The second phase holds the receiver off while requests keep coming.
      hold_phase = (phase == 1);
      if (hold_phase) long_hold_pending = 1'b1;
      batch_len = $urandom_range(4, 16);
      for (int b = 0; b < batch_len && requests_sent < RandomRequests; b++) begin
        send_request(pick_count(), hold_phase ? 0 : pick_idle_len());
        requests_sent++;
      end
      phase++;
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
